// ===== rtl/cwsp_pkg.sv =====
// ----------------------------------------------------------------------------
// cwsp_pkg: shared types for the column width selector packer
// item layouts of the gap input channel and the selector result channel
// ----------------------------------------------------------------------------
package cwsp_pkg;

  localparam int GAP_BITS   = 32;
  localparam int WIDTH_BITS = 6;
  localparam int COUNT_BITS = 24;

  typedef struct packed {
    logic [GAP_BITS-1:0] gap_value;
    logic                last_of_list;
  } gap_item_t;

  typedef struct packed {
    logic [WIDTH_BITS-1:0] sel_width;
    logic                  starts_new_word;
    logic [COUNT_BITS-1:0] words_so_far;
    logic [COUNT_BITS-1:0] selectors_so_far;
    logic                  list_done;
  } sel_item_t;

endpackage

// ===== rtl/column_width_selector_packer_top.sv =====
// ----------------------------------------------------------------------------
// column_width_selector_packer_top: bit width selection for columnar packing
// ors gap values per column, picks the selector width and places columns
// greedily into the lanes of packed words
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid / in_ready / in_item) takes one d-gap value per item,
//   with last_of_list set on the final value of a list.
//   out channel (out_valid / out_ready / out_item) gives one selector item for
//   every closed column: after ROWS_PER_COLUMN values, or at the list's end.
// datapath: an item is caught in the input register, and when it moves on
//   the or, priority encode and lane placement write the result register,
//   which then shows the result of the column that the item closes.
// throughput: one item per cycle while out_ready is high; the input register
//   and the result register form a two-stage pipeline, and the input stage
//   moves on whenever the result register is free or is being drained.
// stall: with out_ready low and a result waiting, the input register holds
//   one more item and in_ready then drops until the result is taken.
// reset: rst (synchronous, active high) empties both stages and clears the
//   column or, row count, lane fill and the word and selector counts.
// ----------------------------------------------------------------------------
module column_width_selector_packer_top #(
  parameter int ROWS_PER_COLUMN = 16,
  parameter int LANE_BITS       = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  cwsp_pkg::gap_item_t in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output cwsp_pkg::sel_item_t out_item
);
  import cwsp_pkg::*;

  // row counter counts 0 .. ROWS_PER_COLUMN-1
  localparam int ROW_W  = $clog2(ROWS_PER_COLUMN);
  // lane fill holds 0 .. LANE_BITS
  localparam int LANE_W = $clog2(LANE_BITS + 1);
  // sum of lane fill and a column width, up to LANE_BITS + 32
  localparam int SUM_W  = $clog2(LANE_BITS + GAP_BITS + 1);

  localparam logic [ROW_W-1:0]      LAST_ROW  = ROW_W'(ROWS_PER_COLUMN - 1);
  localparam logic [SUM_W-1:0]      LANE_SUM  = SUM_W'(LANE_BITS);
  localparam logic [LANE_W-1:0]     LANE_FULL = LANE_W'(LANE_BITS);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // priority encode of the column or; zero counts as width 1
  function automatic logic [WIDTH_BITS-1:0] width_of(input logic [GAP_BITS-1:0] v);
    logic [GAP_BITS-1:0]   x;
    logic [WIDTH_BITS-1:0] r;
    x = v;
    r = WIDTH_BITS'(GAP_BITS);
    if (x == '0) begin
      r = WIDTH_BITS'(1);
    end else begin
      if ((x & 32'hffff0000) == '0) begin x = x << 16; r = r - WIDTH_BITS'(16); end
      if ((x & 32'hff000000) == '0) begin x = x << 8;  r = r - WIDTH_BITS'(8);  end
      if ((x & 32'hf0000000) == '0) begin x = x << 4;  r = r - WIDTH_BITS'(4);  end
      if ((x & 32'hc0000000) == '0) begin x = x << 2;  r = r - WIDTH_BITS'(2);  end
      if ((x & 32'h80000000) == '0) begin r = r - WIDTH_BITS'(1); end
    end
    return r;
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (c == COUNT_MAX) ? c : c + COUNT_BITS'(1);
  endfunction

  // input stage
  logic      s1_valid;
  gap_item_t s1_item;
  logic      s1_fire;

  // column state
  logic [GAP_BITS-1:0]   group_or;
  logic [ROW_W-1:0]      rows_in_group;
  logic [LANE_W-1:0]     lane_bits_used;
  logic [COUNT_BITS-1:0] word_total;
  logic [COUNT_BITS-1:0] selector_total;

  // result stage
  logic      res_valid;
  sel_item_t res_item;

  // combinational column close
  logic [GAP_BITS-1:0]   or_next;
  logic                  closes;
  logic [WIDTH_BITS-1:0] col_w;
  logic [SUM_W-1:0]      lane_sum;
  logic                  fresh;
  logic [LANE_W-1:0]     lane_next;
  logic [COUNT_BITS-1:0] words_next;
  logic [COUNT_BITS-1:0] sels_next;

  // input stage moves when the result slot is free or draining
  assign s1_fire  = s1_valid && (!res_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  always_comb begin
    or_next    = group_or | s1_item.gap_value;
    closes     = s1_item.last_of_list || (rows_in_group == LAST_ROW);
    col_w      = width_of(or_next);
    lane_sum   = SUM_W'(lane_bits_used) + SUM_W'(col_w);
    // no word open yet, or column does not fit the lane bits still free
    fresh      = (lane_bits_used == '0) || (lane_sum > LANE_SUM);
    words_next = fresh ? sat_inc(word_total) : word_total;
    sels_next  = sat_inc(selector_total);
    if (fresh) begin
      // a column wider than the lane fills its word
      lane_next = (SUM_W'(col_w) > LANE_SUM) ? LANE_FULL : LANE_W'(col_w);
    end else begin
      lane_next = LANE_W'(lane_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_or       <= '0;
      rows_in_group  <= '0;
      lane_bits_used <= '0;
      word_total     <= '0;
      selector_total <= '0;
    end else if (s1_fire) begin
      if (!closes) begin
        group_or      <= or_next;
        rows_in_group <= rows_in_group + ROW_W'(1);
      end else begin
        group_or      <= '0;
        rows_in_group <= '0;
        if (s1_item.last_of_list) begin
          // end of list: next value opens a new list
          lane_bits_used <= '0;
          word_total     <= '0;
          selector_total <= '0;
        end else begin
          lane_bits_used <= lane_next;
          word_total     <= words_next;
          selector_total <= sels_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire && closes) begin
      res_valid <= 1'b1;
    end else if (out_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && closes) begin
      res_item.sel_width        <= col_w;
      res_item.starts_new_word  <= fresh;
      res_item.words_so_far     <= words_next;
      res_item.selectors_so_far <= sels_next;
      res_item.list_done        <= s1_item.last_of_list;
    end
  end

  assign out_valid = res_valid;
  assign out_item  = res_item;

  // lane fill never passes the lane size
  a_lane_bound: assert property (@(posedge clk) disable iff (rst)
    lane_bits_used <= LANE_FULL)
    else $error("lane fill beyond lane size");

  // end of list leaves the counts cleared
  a_list_reset: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_item.last_of_list |=>
      lane_bits_used == '0 && word_total == '0 && selector_total == '0 &&
      rows_in_group == '0)
    else $error("state not cleared after end of list");

  // selector width lies in 1..32
  a_width_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.sel_width != '0 &&
      out_item.sel_width <= WIDTH_BITS'(GAP_BITS))
    else $error("selector width out of range");

  // a result never counts more words than selectors
  a_counts_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.words_so_far <= out_item.selectors_so_far &&
      out_item.words_so_far != '0)
    else $error("word count inconsistent with selector count");

  // lane fill is nonzero exactly when the word count is nonzero
  a_word_open: assert property (@(posedge clk) disable iff (rst)
    (lane_bits_used != '0) == (word_total != '0))
    else $error("lane fill and word count disagree");

endmodule
